// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL top level.
// Each macro expects signals clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vdld_pkg.sv =====
// Package for the vector display list decoder: command codes and
// coordinate scaling functions. No dependencies.
package vdld_pkg;

    localparam int unsigned COORD_W = 15;

    localparam logic [7:0] CMD_BRIGHT = 8'd1;
    localparam logic [7:0] CMD_DOT    = 8'd2;
    localparam logic [7:0] CMD_LINE   = 8'd3;
    localparam logic [7:0] CMD_PATH   = 8'd4;
    localparam logic [7:0] CMD_END    = 8'd5;

    localparam logic [7:0] BRIGHT_RESET = 8'h7f;

    localparam logic KIND_SEG = 1'b0;
    localparam logic KIND_END = 1'b1;

    // (raw-128)*128: flip the top bit to get raw-128, then shift by 7
    function automatic logic signed [COORD_W-1:0] scale_x(input logic [7:0] raw);
        return {~raw[7], raw[6:0], 7'b0};
    endfunction

    // (raw-128)*80 = s*64 + s*16
    function automatic logic signed [COORD_W-1:0] scale_y(input logic [7:0] raw);
        logic signed [COORD_W-1:0] s;
        s = COORD_W'(signed'({~raw[7], raw[6:0]}));
        return (s <<< 6) + (s <<< 4);
    endfunction

endpackage

// ===== rtl/vector_display_list_decoder.sv =====
// Vector display list decoder top level: byte parser and segment output.
// Depends on vdld_pkg and assert_macros.svh.
//
//   channel   dir  handshake             payload
//   input     in   in_valid / in_ready   data_byte
//   result    out  out_valid / out_ready kind, start_x, start_y, end_x, end_y, intensity
//
// Each byte passes an input register, then one parser step into the result
// register; one byte per cycle sustained while results are taken.
// A stalled result holds the parser step; the input register still takes one
// more byte while the result waits.
// Reset puts the parser in command wait with brightness 0x7f.
`include "assert_macros.svh"

module vector_display_list_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  kind,
    output logic signed [vdld_pkg::COORD_W-1:0]   start_x,
    output logic signed [vdld_pkg::COORD_W-1:0]   start_y,
    output logic signed [vdld_pkg::COORD_W-1:0]   end_x,
    output logic signed [vdld_pkg::COORD_W-1:0]   end_y,
    output logic [7:0]                            intensity
);

    typedef enum logic [3:0] {
        PH_CMD, PH_BRIGHT, PH_DOT_X, PH_DOT_Y,
        PH_LN_X0, PH_LN_Y0, PH_LN_X1, PH_LN_Y1,
        PH_PA_CNT, PH_PA_X0, PH_PA_Y0, PH_PA_X1, PH_PA_Y1,
        PH_PA_XN, PH_PA_YN
    } phase_t;

    typedef logic signed [vdld_pkg::COORD_W-1:0] coord_t;

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       step;

    phase_t     phase_reg, phase_next;
    logic [7:0] brightness_reg, brightness_next;
    logic [7:0] held_x_reg, held_x_next;
    logic [7:0] first_x_reg, first_x_next;
    logic [7:0] first_y_reg, first_y_next;
    coord_t     last_x_reg, last_x_next;
    coord_t     last_y_reg, last_y_next;
    logic [7:0] points_left_reg, points_left_next;

    logic       out_valid_reg;
    logic       kind_reg, kind_next;
    coord_t     start_x_reg, start_x_next;
    coord_t     start_y_reg, start_y_next;
    coord_t     end_x_reg, end_x_next;
    coord_t     end_y_reg, end_y_next;
    logic [7:0] intensity_reg, intensity_next;
    logic       emit;

    coord_t     cur_x, cur_y;

    assign step     = byte_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || step;

    // held x paired with the byte in hand as y
    assign cur_x = vdld_pkg::scale_x(held_x_reg);
    assign cur_y = vdld_pkg::scale_y(byte_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        brightness_next  = brightness_reg;
        held_x_next      = held_x_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        points_left_next = points_left_reg;
        emit             = 1'b0;
        kind_next        = vdld_pkg::KIND_SEG;
        start_x_next     = cur_x;
        start_y_next     = cur_y;
        end_x_next       = cur_x;
        end_y_next       = cur_y;
        intensity_next   = brightness_reg;
        case (phase_reg)
            PH_BRIGHT:
            begin
                brightness_next = byte_reg;
                phase_next      = PH_CMD;
            end
            PH_DOT_X, PH_LN_X1, PH_PA_X1, PH_PA_XN:
            begin
                held_x_next = byte_reg;
                phase_next  = phase_t'(phase_reg + 4'd1);
            end
            PH_DOT_Y:
            begin
                emit       = 1'b1;
                phase_next = PH_CMD;
            end
            PH_LN_X0, PH_PA_X0:
            begin
                first_x_next = byte_reg;
                phase_next   = phase_t'(phase_reg + 4'd1);
            end
            PH_LN_Y0, PH_PA_Y0:
            begin
                first_y_next = byte_reg;
                phase_next   = phase_t'(phase_reg + 4'd1);
            end
            PH_LN_Y1:
            begin
                emit         = 1'b1;
                start_x_next = vdld_pkg::scale_x(first_x_reg);
                start_y_next = vdld_pkg::scale_y(first_y_reg);
                phase_next   = PH_CMD;
            end
            PH_PA_CNT:
            begin
                points_left_next = (byte_reg == 8'd0) ? 8'd0 : byte_reg - 8'd1;
                phase_next       = PH_PA_X0;
            end
            PH_PA_Y1:
            begin
                emit         = 1'b1;
                start_x_next = vdld_pkg::scale_x(first_x_reg);
                start_y_next = vdld_pkg::scale_y(first_y_reg);
                last_x_next  = cur_x;
                last_y_next  = cur_y;
                phase_next   = (points_left_reg == 8'd0) ? PH_CMD : PH_PA_XN;
            end
            PH_PA_YN:
            begin
                emit         = 1'b1;
                start_x_next = last_x_reg;
                start_y_next = last_y_reg;
                last_x_next  = cur_x;
                last_y_next  = cur_y;
                // count down, then stop on the last point
                if (points_left_reg != 8'd0)
                begin
                    points_left_next = points_left_reg - 8'd1;
                end
                phase_next = (points_left_reg <= 8'd1) ? PH_CMD : PH_PA_XN;
            end
            default:
            begin
                case (byte_reg)
                    vdld_pkg::CMD_BRIGHT: phase_next = PH_BRIGHT;
                    vdld_pkg::CMD_DOT:    phase_next = PH_DOT_X;
                    vdld_pkg::CMD_LINE:   phase_next = PH_LN_X0;
                    vdld_pkg::CMD_PATH:   phase_next = PH_PA_CNT;
                    vdld_pkg::CMD_END:
                    begin
                        emit           = 1'b1;
                        kind_next      = vdld_pkg::KIND_END;
                        start_x_next   = '0;
                        start_y_next   = '0;
                        end_x_next     = '0;
                        end_y_next     = '0;
                        intensity_next = '0;
                        phase_next     = PH_CMD;
                    end
                    // drop unknown commands
                    default:              phase_next = PH_CMD;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_CMD;
            brightness_reg  <= vdld_pkg::BRIGHT_RESET;
            held_x_reg      <= '0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            points_left_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg   <= emit;
                phase_reg       <= phase_next;
                brightness_reg  <= brightness_next;
                held_x_reg      <= held_x_next;
                first_x_reg     <= first_x_next;
                first_y_reg     <= first_y_next;
                last_x_reg      <= last_x_next;
                last_y_reg      <= last_y_next;
                points_left_reg <= points_left_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
        if (step && emit)
        begin
            kind_reg      <= kind_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            intensity_reg <= intensity_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign start_x   = start_x_reg;
    assign start_y   = start_y_reg;
    assign end_x     = end_x_reg;
    assign end_y     = end_y_reg;
    assign intensity = intensity_reg;

    `ASSERT_IMPL(a_end_zero, out_valid && kind == vdld_pkg::KIND_END, start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0 && intensity == '0, "end marker with nonzero fields")
    `ASSERT_NEXT(a_hold_byte, byte_valid_reg && out_valid && !out_ready, byte_valid_reg, "pending byte lost during stall")
    `ASSERT_NEXT(a_result_from_step, !step && !out_valid, !out_valid, "result appeared without a parser step")

endmodule

// ===== bench/tb_vector_display_list_decoder.sv =====
// Self-checking bench for vector_display_list_decoder: directed and random display lists in,
// segments and end markers predicted and compared as they come out.
// Depends on vdld_pkg and the RTL top level.
module tb_vector_display_list_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 600;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;

    typedef enum logic [3:0] {
        AWAIT_CMD, GET_LEVEL, DOT_X, DOT_Y,
        LINE_X0, LINE_Y0, LINE_X1, LINE_Y1,
        PATH_COUNT, PATH_X0, PATH_Y0, PATH_X1, PATH_Y1, PATH_XN, PATH_YN
    } list_phase_t;

    typedef struct packed {
        logic [7:0] value;
        logic       hold;   // wait for all segments to drain before sending
    } list_byte_t;

    typedef struct packed {
        logic                                kind;
        logic signed [vdld_pkg::COORD_W-1:0] sx;
        logic signed [vdld_pkg::COORD_W-1:0] sy;
        logic signed [vdld_pkg::COORD_W-1:0] ex;
        logic signed [vdld_pkg::COORD_W-1:0] ey;
        logic [7:0]                          level;
    } segment_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [7:0]                          data_byte = 8'd0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                kind;
    logic signed [vdld_pkg::COORD_W-1:0] start_x;
    logic signed [vdld_pkg::COORD_W-1:0] start_y;
    logic signed [vdld_pkg::COORD_W-1:0] end_x;
    logic signed [vdld_pkg::COORD_W-1:0] end_y;
    logic [7:0]                          intensity;

    vector_display_list_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .intensity (intensity)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    list_byte_t byte_queue[$];
    segment_t   seg_expected[$];
    int         mismatches = 0;
    int         queued = 0;
    logic       hold_next = 1'b0;

    // parser copy
    list_phase_t                         phase = AWAIT_CMD;
    logic [7:0]                          level = vdld_pkg::BRIGHT_RESET;
    logic [7:0]                          pend_x = 8'd0;
    logic [7:0]                          org_x = 8'd0;
    logic [7:0]                          org_y = 8'd0;
    logic signed [vdld_pkg::COORD_W-1:0] tail_x = '0;
    logic signed [vdld_pkg::COORD_W-1:0] tail_y = '0;
    logic [7:0]                          points_left = 8'd0;

    function automatic logic signed [vdld_pkg::COORD_W-1:0] screen_x(input logic [7:0] raw);
        int v;
        v = (int'(raw) - 128) * 128;
        return v[vdld_pkg::COORD_W-1:0];
    endfunction

    function automatic logic signed [vdld_pkg::COORD_W-1:0] screen_y(input logic [7:0] raw);
        int v;
        v = (int'(raw) - 128) * 80;
        return v[vdld_pkg::COORD_W-1:0];
    endfunction

    task automatic queue_segment(input logic signed [vdld_pkg::COORD_W-1:0] sx,
                                 input logic signed [vdld_pkg::COORD_W-1:0] sy,
                                 input logic signed [vdld_pkg::COORD_W-1:0] ex,
                                 input logic signed [vdld_pkg::COORD_W-1:0] ey);
        seg_expected.push_back('{vdld_pkg::KIND_SEG, sx, sy, ex, ey, level});
    endtask

    task automatic decode_byte(input logic [7:0] b);
        case (phase)
            GET_LEVEL:
            begin
                level = b;
                phase = AWAIT_CMD;
            end
            DOT_X:
            begin
                pend_x = b;
                phase = DOT_Y;
            end
            DOT_Y:
            begin
                queue_segment(screen_x(pend_x), screen_y(b), screen_x(pend_x), screen_y(b));
                phase = AWAIT_CMD;
            end
            LINE_X0, PATH_X0:
            begin
                org_x = b;
                phase = (phase == LINE_X0) ? LINE_Y0 : PATH_Y0;
            end
            LINE_Y0, PATH_Y0:
            begin
                org_y = b;
                phase = (phase == LINE_Y0) ? LINE_X1 : PATH_X1;
            end
            LINE_X1, PATH_X1:
            begin
                pend_x = b;
                phase = (phase == LINE_X1) ? LINE_Y1 : PATH_Y1;
            end
            LINE_Y1:
            begin
                queue_segment(screen_x(org_x), screen_y(org_y), screen_x(pend_x), screen_y(b));
                phase = AWAIT_CMD;
            end
            PATH_COUNT:
            begin
                points_left = (b == 8'd0) ? 8'd0 : b - 8'd1;
                phase = PATH_X0;
            end
            PATH_Y1:
            begin
                queue_segment(screen_x(org_x), screen_y(org_y), screen_x(pend_x), screen_y(b));
                tail_x = screen_x(pend_x);
                tail_y = screen_y(b);
                phase = (points_left == 8'd0) ? AWAIT_CMD : PATH_XN;
            end
            PATH_XN:
            begin
                pend_x = b;
                phase = PATH_YN;
            end
            PATH_YN:
            begin
                queue_segment(tail_x, tail_y, screen_x(pend_x), screen_y(b));
                tail_x = screen_x(pend_x);
                tail_y = screen_y(b);
                if (points_left != 8'd0)
                    points_left = points_left - 8'd1;
                phase = (points_left == 8'd0) ? AWAIT_CMD : PATH_XN;
            end
            default:
            begin
                case (b)
                    vdld_pkg::CMD_BRIGHT: phase = GET_LEVEL;
                    vdld_pkg::CMD_DOT:    phase = DOT_X;
                    vdld_pkg::CMD_LINE:   phase = LINE_X0;
                    vdld_pkg::CMD_PATH:   phase = PATH_COUNT;
                    vdld_pkg::CMD_END:
                    begin
                        seg_expected.push_back('{vdld_pkg::KIND_END, '0, '0, '0, '0, 8'd0});
                        phase = AWAIT_CMD;
                    end
                    default:              phase = AWAIT_CMD;
                endcase
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(127, 128));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] v);
        byte_queue.push_back('{v, hold_next});
        hold_next = 1'b0;
        queued++;
    endtask

    task automatic add_points(input int pairs);
        for (int i = 0; i < pairs; i++)
        begin
            add_byte(pick_coord());
            add_byte(pick_coord());
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic signed [15:0] want_v,
                                        input logic signed [15:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    // driver
    int         tx_gap = 0;
    int         tx_burst = 0;
    logic       next_valid;
    list_byte_t tx_item;
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && !in_ready))
        begin
            if (in_valid && in_ready)
                decode_byte(data_byte);
            next_valid = 1'b0;
            if (tx_gap > 0)
                tx_gap--;
            else if (byte_queue.size() != 0
                     && !(byte_queue[0].hold && seg_expected.size() != 0))
            begin
                tx_item = byte_queue.pop_front();
                data_byte <= tx_item.value;
                next_valid = 1'b1;
                if (tx_burst > 0)
                    tx_burst--;
                else if ($urandom_range(0, 39) == 0)
                    tx_burst = $urandom_range(20, 60);
                else
                    tx_gap = pick_gap();
            end
            in_valid <= next_valid;
        end
    end

    // monitor
    int       rx_gap = 0;
    int       rx_burst = 0;
    segment_t want;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (seg_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, kind %0d", $time, kind);
                end
                else
                begin
                    want = seg_expected.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("start_x", want.sx, start_x);
                    check_field("start_y", want.sy, start_y);
                    check_field("end_x", want.ex, end_x);
                    check_field("end_y", want.ey, end_y);
                    check_field("intensity", want.level, intensity);
                end
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_burst > 0)
                    rx_burst--;
                else if ($urandom_range(0, 39) == 0)
                    rx_burst = $urandom_range(20, 60);
                else
                    rx_gap = pick_gap();
            end
        end
    end

    // watchdog: nothing moving on either side for too long
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress, %0d segments outstanding",
                         $time, seg_expected.size());
                $display("tb_vector_display_list_decoder NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int count;
        int goal;

        // end marker and dot under reset brightness
        add_byte(vdld_pkg::CMD_END);
        add_byte(vdld_pkg::CMD_DOT); add_byte(8'd0); add_byte(8'd255);
        // unknown commands, zero included
        add_byte(8'd0); add_byte(8'd6); add_byte(8'd255);
        add_byte(vdld_pkg::CMD_BRIGHT); add_byte(8'd0);
        add_byte(vdld_pkg::CMD_DOT); add_byte(8'd255); add_byte(8'd0);
        add_byte(vdld_pkg::CMD_LINE);
        add_byte(8'd0); add_byte(8'd0); add_byte(8'd255); add_byte(8'd255);
        // path with count zero draws just the first segment
        add_byte(vdld_pkg::CMD_PATH); add_byte(8'd0);
        add_byte(8'd128); add_byte(8'd128); add_byte(8'd1); add_byte(8'd254);

        // drain fully before the random lists start
        hold_next = 1'b1;
        goal = queued + RANDOM_BYTES;
        while (queued < goal)
        begin
            if ($urandom_range(0, 49) == 0)
                hold_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                add_byte(vdld_pkg::CMD_BRIGHT);
                add_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 25)
            begin
                add_byte(vdld_pkg::CMD_DOT);
                add_points(1);
            end
            else if (r < 45)
            begin
                add_byte(vdld_pkg::CMD_LINE);
                add_points(2);
            end
            else if (r < 75)
            begin
                // long paths only while the byte budget still has room for them
                if ($urandom_range(0, 99) == 0 && goal - queued > 520)
                    count = $urandom_range(0, 1) ? 255 : $urandom_range(8, 254);
                else
                    count = $urandom_range(0, 6);
                add_byte(vdld_pkg::CMD_PATH);
                add_byte(8'(count));
                add_points(count < 2 ? 2 : count + 1);
            end
            else if (r < 85)
                add_byte(vdld_pkg::CMD_END);
            else if (r < 93)
                add_byte(r[0] ? 8'd0 : 8'($urandom_range(6, 255)));
            else
                add_byte(8'($urandom_range(0, 255)));   // stray byte, may break the next list
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (seg_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && seg_expected.size() == 0)
            $display("tb_vector_display_list_decoder OK");
        else
            $display("tb_vector_display_list_decoder NOT OK");
        $finish;
    end

endmodule
